[design/tma_pkg.sv]
`timescale 1ns / 1ps

package tma_pkg;

  // Default arithmetic format: signed Q16.16 in a 32-bit word
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // Divider geometry, fixed by the 32-bit bounds
  localparam int DIV_NUM_BITS = 64;
  localparam int DIV_DEN_BITS = 33;

  // Opcodes
  localparam logic [2:0] OP_IDENT     = 3'd0;
  localparam logic [2:0] OP_SCALE     = 3'd1;
  localparam logic [2:0] OP_TRANSLATE = 3'd2;
  localparam logic [2:0] OP_FRUSTUM   = 3'd3;
  localparam logic [2:0] OP_ORTHO     = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_e;
    logic signed [31:0] arg_f;
  } tma_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] element;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic               last;
  } tma_result_t;

endpackage

[design/tma_div.sv]
`timescale 1ns / 1ps

module tma_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tma_pkg::DIV_NUM_BITS-1:0]   num,
  input  logic [tma_pkg::DIV_DEN_BITS-1:0]   den,
  output logic                               done,
  output logic [tma_pkg::DIV_NUM_BITS-1:0]   quot
);
  import tma_pkg::*;

  localparam int CNTW = $clog2(DIV_NUM_BITS + 1);

  logic                    busy;
  logic [CNTW-1:0]         cnt;
  logic [DIV_DEN_BITS-1:0] rem;
  logic [DIV_DEN_BITS-1:0] dreg;
  logic [DIV_DEN_BITS:0]   trial;
  logic                    ge;

  // One quotient bit a cycle, restoring
  assign trial = {rem, quot[DIV_NUM_BITS-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIV_NUM_BITS);
        quot <= num;
        rem  <= '0;
        dreg <= den;
      end else if (busy) begin
        rem  <= ge ? DIV_DEN_BITS'(trial - {1'b0, dreg}) : DIV_DEN_BITS'(trial);
        quot <= {quot[DIV_NUM_BITS-2:0], ge};
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/tma_mul.sv]
`timescale 1ns / 1ps

module tma_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int ND   = (BW + 15) / 16;
  localparam int BPW  = 16 * ND;
  localparam int ACCW = AW + BPW;
  localparam int PPW  = AW + 16;
  localparam int CNTW = $clog2(ND + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [AW-1:0]   areg;
  logic [BPW-1:0]  breg;
  logic [ACCW-1:0] acc;
  logic [PPW-1:0]  pp;

  // Sixteen bits of b a cycle, most significant digit first
  assign pp   = PPW'(areg) * PPW'(breg[BPW-1 -: 16]);
  assign prod = acc[AW+BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(ND);
        areg <= a;
        breg <= BPW'(b);
        acc  <= '0;
      end else if (busy) begin
        acc  <= (acc << 16) + ACCW'(pp);
        breg <= breg << 16;
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/transform_matrix_accumulator_top.sv]
`timescale 1ns / 1ps

// Transform matrix accumulator. Holds one 4x4 matrix of signed fixed-point
// words (FRAC_BITS fraction bits, WORD_BITS wide) in a 16-entry synchronous
// memory and applies one opcode per item: load identity, scale rows 0..2,
// translate into row 3, premultiply by a frustum or orthographic matrix, or
// read the matrix out row-major as 16 result items. One item is in work at a
// time; the next is taken as soon as the current one has handed its last
// result to the output register. Every matrix update runs column by column:
// four memory reads fill a column buffer, then each row entry is formed by a
// sequential multiplier (one 16-bit digit of the matrix word a cycle) and
// written back, so reads of a column always finish before it is overwritten
// and no forwarding is needed. Terms whose coefficient is zero are skipped
// without starting the multiplier.
// Frustum and ortho first build their matrix with six divisions on one
// shared bit-serial divider, then premultiply with at most seven non-zero
// terms per column; rejected bounds skip the divisions and give their result
// item straight after the bound check. After reset the block runs an
// identity pass, with no result, before taking an item.
module transform_matrix_accumulator_top #(
  parameter int FRAC_BITS = tma_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = tma_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tma_pkg::tma_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tma_pkg::tma_result_t result
);
  import tma_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = (W > 32) ? W : 32;   // coefficient width
  localparam int PW = CW + W;              // full product width
  localparam int SW = (PW > DIV_NUM_BITS) ? PW : DIV_NUM_BITS;
  localparam int AW = W + 3;               // base plus four terms

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_Q =
    (F >= W - 1) ? MAXW : (W'(1) << F);
  localparam logic signed [W-1:0] NEG_ONE_Q = -ONE_Q;
  localparam logic [2:0] LAST_JOB = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV_START, S_DIV_WAIT, S_COL_RD, S_COL_CAP, S_ROW,
    S_TERM, S_MUL_WAIT, S_ACCUM, S_WRITE, S_DONE, S_RD_REQ, S_RD_WAIT
  } state_t;

  // Saturate a magnitude with sign to the word range
  function automatic logic [W-1:0] sat_mag(input logic neg, input logic [SW-1:0] m);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = |m[SW-1:W-1];
    neg_ovf = (|m[SW-1:W]) || (m[W-1] && (|m[W-2:0]));
    if (!neg) sat_mag = pos_ovf ? MAXW : m[W-1:0];
    else      sat_mag = neg_ovf ? MINW : ((~m[W-1:0]) + W'(1));
  endfunction

  function automatic logic [W-1:0] clamp_acc(input logic signed [AW-1:0] a);
    logic all_zero;
    logic all_one;
    all_zero = ~|a[AW-1:W-1];
    all_one  = &a[AW-1:W-1];
    if (!a[AW-1] && !all_zero)     clamp_acc = MAXW;
    else if (a[AW-1] && !all_one)  clamp_acc = MINW;
    else                           clamp_acc = a[W-1:0];
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] x);
    abs33 = x[32] ? 33'(-x) : 33'(x);
  endfunction

  state_t                state;
  logic                  init;     // reset identity pass, no result
  logic [2:0]            mode;
  tma_item_t             itm;
  logic                  status;
  logic [2:0]            job;
  logic                  dneg;
  logic [3:0]            ddest;
  logic [1:0]            ci, cj, ck, rk;
  logic [3:0]            rd_idx;
  logic                  mneg;
  logic signed [AW-1:0]  acc;
  logic signed [32:0]    dx, dy, dz, srl, stb, snf;
  logic [61:0]           nf;
  logic signed [W-1:0]   coef_m [16];
  logic signed [W-1:0]   col [4];

  // Matrix store
  logic signed [W-1:0]   mem [16];
  logic signed [W-1:0]   mem_rdata;
  logic                  mem_we, mem_re;
  logic [3:0]            mem_waddr, mem_raddr;
  logic [W-1:0]          mem_wdata;

  // Combinational helpers
  logic                  free;
  logic                  issue;
  logic signed [32:0]    dx_c, dy_c, dz_c;
  logic                  rej_f, rej_o;
  logic [1:0]            colsel_idx;
  logic signed [W-1:0]   col_sel;
  logic signed [CW-1:0]  coef_c;
  logic signed [AW-1:0]  base_c;
  logic [CW-1:0]         mul_a;
  logic [W-1:0]          mul_b;
  logic                  mul_start, mul_done;
  logic [PW-1:0]         mul_prod;
  logic signed [W-1:0]   term_c;
  logic [DIV_NUM_BITS-1:0] num_sel;
  logic signed [32:0]    den_sel;
  logic                  neg_sel;
  logic [3:0]            dest_sel;
  logic                  div_start, div_done;
  logic [DIV_NUM_BITS-1:0] div_quot;
  logic [DIV_NUM_BITS-1:0] two_q;
  logic signed [63:0]    elem_wide;

  assign item_ready = (state == S_IDLE);
  assign free       = !result_valid || result_ready;
  // A new result item is loaded into the output register this cycle
  assign issue      = free && ((state == S_DONE) || (state == S_RD_WAIT));

  // Extents and bound checks from the held item
  assign dx_c  = {itm.arg_b[31], itm.arg_b} - {itm.arg_a[31], itm.arg_a};
  assign dy_c  = {itm.arg_d[31], itm.arg_d} - {itm.arg_c[31], itm.arg_c};
  assign dz_c  = {itm.arg_f[31], itm.arg_f} - {itm.arg_e[31], itm.arg_e};
  assign rej_f = (itm.arg_e <= 32'sd0) || (itm.arg_f <= 32'sd0) ||
                 (dx_c <= 33'sd0) || (dy_c <= 33'sd0) || (dz_c <= 33'sd0);
  assign rej_o = (dx_c == 33'sd0) || (dy_c == 33'sd0) || (dz_c == 33'sd0);

  // One column-buffer read port: base row in S_ROW, term row otherwise
  assign colsel_idx = (state == S_ROW) ? ci : ck;
  assign col_sel    = col[colsel_idx];

  always_comb begin
    coef_c = '0;
    case (mode)
      OP_SCALE: begin
        if (ci == ck && ci != 2'd3) begin
          case (ci)
            2'd0:    coef_c = CW'(itm.arg_a);
            2'd1:    coef_c = CW'(itm.arg_b);
            default: coef_c = CW'(itm.arg_c);
          endcase
        end
      end
      OP_TRANSLATE: begin
        if (ci == 2'd3 && ck != 2'd3) begin
          case (ck)
            2'd0:    coef_c = CW'(itm.arg_a);
            2'd1:    coef_c = CW'(itm.arg_b);
            default: coef_c = CW'(itm.arg_c);
          endcase
        end
      end
      OP_FRUSTUM, OP_ORTHO: coef_c = CW'(coef_m[{ci, ck}]);
      default: coef_c = '0;
    endcase
  end

  always_comb begin
    case (mode)
      OP_IDENT:     base_c = (ci == cj) ? AW'(ONE_Q) : '0;
      OP_SCALE:     base_c = (ci == 2'd3) ? AW'(col_sel) : '0;
      OP_TRANSLATE: base_c = AW'(col_sel);
      default:      base_c = '0;
    endcase
  end

  assign mul_a     = coef_c[CW-1] ? CW'(-coef_c) : CW'(coef_c);
  assign mul_b     = col_sel[W-1] ? W'(-col_sel) : W'(col_sel);
  assign mul_start = (state == S_TERM) && (coef_c != '0);
  assign term_c    = sat_mag(mneg, SW'(mul_prod >> F));

  tma_mul #(.AW(CW), .BW(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Division jobs that build the projection matrix
  assign two_q = DIV_NUM_BITS'(1) << (2 * F + 1);

  always_comb begin
    num_sel  = '0;
    den_sel  = dx;
    neg_sel  = 1'b0;
    dest_sel = 4'd0;
    if (mode == OP_FRUSTUM) begin
      case (job)
        3'd0: begin
          num_sel = DIV_NUM_BITS'(itm.arg_e[30:0]) << (F + 1);
          den_sel = dx; dest_sel = 4'd0;
        end
        3'd1: begin
          num_sel = DIV_NUM_BITS'(itm.arg_e[30:0]) << (F + 1);
          den_sel = dy; dest_sel = 4'd5;
        end
        3'd2: begin
          num_sel = DIV_NUM_BITS'(abs33(srl)) << F;
          den_sel = dx; neg_sel = srl[32]; dest_sel = 4'd8;
        end
        3'd3: begin
          num_sel = DIV_NUM_BITS'(abs33(stb)) << F;
          den_sel = dy; neg_sel = stb[32]; dest_sel = 4'd9;
        end
        3'd4: begin
          num_sel = DIV_NUM_BITS'(abs33(snf)) << F;
          den_sel = dz; neg_sel = 1'b1; dest_sel = 4'd10;
        end
        default: begin
          num_sel = DIV_NUM_BITS'(nf) << 1;
          den_sel = dz; neg_sel = 1'b1; dest_sel = 4'd14;
        end
      endcase
    end else begin
      case (job)
        3'd0: begin
          num_sel = two_q; den_sel = dx; dest_sel = 4'd0;
        end
        3'd1: begin
          num_sel = DIV_NUM_BITS'(abs33(srl)) << F;
          den_sel = dx; neg_sel = !srl[32] && (srl != 33'sd0); dest_sel = 4'd12;
        end
        3'd2: begin
          num_sel = two_q; den_sel = dy; dest_sel = 4'd5;
        end
        3'd3: begin
          num_sel = DIV_NUM_BITS'(abs33(stb)) << F;
          den_sel = dy; neg_sel = !stb[32] && (stb != 33'sd0); dest_sel = 4'd13;
        end
        3'd4: begin
          num_sel = two_q; den_sel = dz; neg_sel = 1'b1; dest_sel = 4'd10;
        end
        default: begin
          num_sel = DIV_NUM_BITS'(abs33(snf)) << F;
          den_sel = dz; neg_sel = !snf[32] && (snf != 33'sd0); dest_sel = 4'd14;
        end
      endcase
    end
  end

  assign div_start = (state == S_DIV_START);

  tma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_sel),
    .den   (abs33(den_sel)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Memory ports
  assign mem_we    = (state == S_WRITE);
  assign mem_waddr = {ci, cj};
  assign mem_wdata = clamp_acc(acc);
  assign mem_re    = (state == S_COL_RD) || (state == S_RD_REQ);
  assign mem_raddr = (state == S_RD_REQ) ? rd_idx : {rk, cj};
  assign elem_wide = 64'(mem_rdata);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_COL_RD;
      init         <= 1'b1;
      mode         <= OP_IDENT;
      cj           <= 2'd0;
      rk           <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready && !issue) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            itm    <= item;
            mode   <= item.opcode;
            status <= 1'b0;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          dx  <= dx_c;
          dy  <= dy_c;
          dz  <= dz_c;
          srl <= {itm.arg_b[31], itm.arg_b} + {itm.arg_a[31], itm.arg_a};
          stb <= {itm.arg_d[31], itm.arg_d} + {itm.arg_c[31], itm.arg_c};
          snf <= {itm.arg_f[31], itm.arg_f} + {itm.arg_e[31], itm.arg_e};
          nf  <= 62'(itm.arg_e[30:0]) * 62'(itm.arg_f[30:0]);
          // Clear the coefficients, keeping the fixed entry of each projection
          for (int e = 0; e < 16; e++) begin
            if (e == 11 && mode == OP_FRUSTUM)    coef_m[e] <= NEG_ONE_Q;
            else if (e == 15 && mode == OP_ORTHO) coef_m[e] <= ONE_Q;
            else                                  coef_m[e] <= '0;
          end
          job <= 3'd0;
          cj  <= 2'd0;
          rk  <= 2'd0;
          case (mode)
            OP_IDENT, OP_SCALE, OP_TRANSLATE: state <= S_COL_RD;
            OP_FRUSTUM: begin
              if (rej_f) begin
                status <= 1'b1;
                state  <= S_DONE;
              end else begin
                state <= S_DIV_START;
              end
            end
            OP_ORTHO: begin
              if (rej_o) begin
                status <= 1'b1;
                state  <= S_DONE;
              end else begin
                state <= S_DIV_START;
              end
            end
            OP_READ: begin
              rd_idx <= 4'd0;
              state  <= S_RD_REQ;
            end
            default: state <= S_DONE;
          endcase
        end
        S_DIV_START: begin
          dneg  <= neg_sel ^ den_sel[32];
          ddest <= dest_sel;
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            coef_m[ddest] <= sat_mag(dneg, SW'(div_quot));
            if (job == LAST_JOB) begin
              state <= S_COL_RD;
            end else begin
              job   <= job + 3'd1;
              state <= S_DIV_START;
            end
          end
        end
        S_COL_RD: state <= S_COL_CAP;
        S_COL_CAP: begin
          col[rk] <= mem_rdata;
          rk      <= rk + 2'd1;
          if (rk == 2'd3) begin
            ci    <= 2'd0;
            state <= S_ROW;
          end else begin
            state <= S_COL_RD;
          end
        end
        S_ROW: begin
          acc   <= base_c;
          ck    <= 2'd0;
          state <= S_TERM;
        end
        S_TERM: begin
          if (coef_c == '0) begin
            // zero coefficient: the term is zero, skip it
            if (ck == 2'd3) state <= S_WRITE;
            else            ck <= ck + 2'd1;
          end else begin
            mneg  <= coef_c[CW-1] ^ col_sel[W-1];
            state <= S_MUL_WAIT;
          end
        end
        S_MUL_WAIT: begin
          if (mul_done) state <= S_ACCUM;
        end
        S_ACCUM: begin
          acc <= acc + AW'(term_c);
          if (ck == 2'd3) begin
            state <= S_WRITE;
          end else begin
            ck    <= ck + 2'd1;
            state <= S_TERM;
          end
        end
        S_WRITE: begin
          if (ci == 2'd3) begin
            if (cj == 2'd3) begin
              if (init) begin
                init  <= 1'b0;
                state <= S_IDLE;
              end else begin
                state <= S_DONE;
              end
            end else begin
              cj    <= cj + 2'd1;
              rk    <= 2'd0;
              state <= S_COL_RD;
            end
          end else begin
            ci    <= ci + 2'd1;
            state <= S_ROW;
          end
        end
        S_DONE: begin
          if (free) begin
            result_valid     <= 1'b1;
            result.status    <= status;
            result.element   <= '0;
            result.row_index <= 2'd0;
            result.col_index <= 2'd0;
            result.last      <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_RD_REQ: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (free) begin
            result_valid     <= 1'b1;
            result.status    <= 1'b0;
            result.element   <= elem_wide[31:0];
            result.row_index <= rd_idx[3:2];
            result.col_index <= rd_idx[1:0];
            result.last      <= (rd_idx == 4'd15);
            rd_idx           <= rd_idx + 4'd1;
            state            <= (rd_idx == 4'd15) ? S_IDLE : S_RD_REQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/tma_checker.sv]
`timescale 1ns / 1ps

module tma_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input tma_pkg::tma_item_t   item,
  input logic                 result_valid,
  input logic                 result_ready,
  input tma_pkg::tma_result_t result
);
  import tma_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Drop ready for the cycle after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while busy");

  // Only the final item of an operation may carry a rejection
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.last && (result.element == 32'sd0))
    else $error("rejection on a read-out item");

  // A non-final item carries no rejection and is never at position (3,3)
  a_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> !result.status &&
      !(result.row_index == 2'd3 && result.col_index == 2'd3))
    else $error("read-out position out of order");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind transform_matrix_accumulator_top tma_props u_tma_props (.*);

[dv/tma_checker.sv]
`timescale 1ns / 1ps

module tma_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  tma_pkg::tma_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  tma_pkg::tma_result_t result,
  output int                   errors,
  output int                   pending
);
  import tma_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint ONE  = 64'sd1 << FRAC_BITS_DEF;

  longint      mat [16];
  tma_result_t expected_results[$];

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat_mag(bit neg, logic [63:0] mag);
    if (!neg) return (mag > WMAX) ? WMAX : longint'(mag);
    if (mag > WMAX + 1) return -WMAX - 1;
    return -longint'(mag);
  endfunction

  function automatic longint clamp(longint v);
    if (v > WMAX) return WMAX;
    if (v < -WMAX - 1) return -WMAX - 1;
    return v;
  endfunction

  // magnitudes stay within 2^31, so the product fits in 64 bits
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] p;
    p = abs64(a) * abs64(b);
    return sat_mag((a < 0) != (b < 0), p >> FRAC_BITS_DEF);
  endfunction

  function automatic longint fx_div(bit neg, logic [63:0] num, longint den);
    if (den == 0) return 0;
    if (den < 0) neg = !neg;
    return sat_mag(neg, num / abs64(den));
  endfunction

  task automatic set_identity(output longint m[16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
  endtask

  task automatic premultiply(input longint a[16]);
    longint t[16];
    longint acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_mul(a[i*4+k], mat[k*4+j]);
        t[i*4+j] = clamp(acc);
      end
    mat = t;
  endtask

  // Apply one item to the matrix copy and queue the results it causes
  task automatic predict_item(input tma_item_t it);
    longint l, r, b, t, n, f, dx, dy, dz, s, acc;
    longint bm[16];
    logic [63:0] two;
    tma_result_t res;
    bit rej;
    l = it.arg_a; r = it.arg_b; b = it.arg_c;
    t = it.arg_d; n = it.arg_e; f = it.arg_f;
    dx = r - l; dy = t - b; dz = f - n;
    two = 64'd1 << (2 * FRAC_BITS_DEF + 1);
    rej = 0;
    res = '0;
    if (it.opcode == OP_READ) begin
      for (int i = 0; i < 16; i++) begin
        res.element   = mat[i][31:0];
        res.row_index = i[3:2];
        res.col_index = i[1:0];
        res.last      = (i == 15);
        expected_results.push_back(res);
      end
      return;
    end
    case (it.opcode)
      OP_IDENT: set_identity(mat);
      OP_SCALE: begin
        for (int j = 0; j < 4; j++) begin
          mat[j]   = fx_mul(mat[j], l);
          mat[4+j] = fx_mul(mat[4+j], r);
          mat[8+j] = fx_mul(mat[8+j], b);
        end
      end
      OP_TRANSLATE: begin
        for (int j = 0; j < 4; j++) begin
          acc = mat[12+j] + fx_mul(mat[j], l) + fx_mul(mat[4+j], r)
              + fx_mul(mat[8+j], b);
          mat[12+j] = clamp(acc);
        end
      end
      OP_FRUSTUM: begin
        if (n <= 0 || f <= 0 || dx <= 0 || dy <= 0 || dz <= 0) rej = 1;
        else begin
          for (int i = 0; i < 16; i++) bm[i] = 0;
          bm[0]  = fx_div(0, n << (FRAC_BITS_DEF + 1), dx);
          bm[5]  = fx_div(0, n << (FRAC_BITS_DEF + 1), dy);
          s = r + l;
          bm[8]  = fx_div(s < 0, abs64(s) << FRAC_BITS_DEF, dx);
          s = t + b;
          bm[9]  = fx_div(s < 0, abs64(s) << FRAC_BITS_DEF, dy);
          bm[10] = fx_div(1, (n + f) << FRAC_BITS_DEF, dz);
          bm[11] = -ONE;
          bm[14] = fx_div(1, n * f * 2, dz);
          premultiply(bm);
        end
      end
      OP_ORTHO: begin
        if (dx == 0 || dy == 0 || dz == 0) rej = 1;
        else begin
          set_identity(bm);
          bm[0]  = fx_div(0, two, dx);
          s = r + l;
          bm[12] = fx_div(s > 0, abs64(s) << FRAC_BITS_DEF, dx);
          bm[5]  = fx_div(0, two, dy);
          s = t + b;
          bm[13] = fx_div(s > 0, abs64(s) << FRAC_BITS_DEF, dy);
          bm[10] = fx_div(1, two, dz);
          s = n + f;
          bm[14] = fx_div(s > 0, abs64(s) << FRAC_BITS_DEF, dz);
          premultiply(bm);
        end
      end
      default: ;
    endcase
    res.status = rej;
    res.last   = 1'b1;
    expected_results.push_back(res);
  endtask

  initial begin
    errors = 0;
    set_identity(mat);
  end

  assign pending = expected_results.size();

  // Check the result first, then predict: an item taken at this edge
  // cannot have produced the result taken at the same edge
  always @(posedge clk) begin
    tma_result_t exp_res;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, result);
        end else begin
          exp_res = expected_results.pop_front();
          if (result.status !== exp_res.status || result.element !== exp_res.element ||
              result.row_index !== exp_res.row_index ||
              result.col_index !== exp_res.col_index || result.last !== exp_res.last) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_res, result);
          end
        end
      end
      if (item_valid && item_ready) predict_item(item);
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tma_pkg::*;

  localparam int QONE     = 1 << FRAC_BITS_DEF;
  localparam int WD_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        item_valid = 0;
  logic        item_ready;
  tma_item_t   item = '0;
  logic        result_valid;
  logic        result_ready = 0;
  tma_result_t result;
  int          errors;
  int          pending;
  int          in_idle  = 0;
  int          out_idle = 0;
  int          quiet_cycles = 0;

  always #6 clk = ~clk;

  transform_matrix_accumulator_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  tma_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .errors(errors), .pending(pending)
  );

  // Receiver: drop ready at random, per the current idle percentage
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= out_idle);
  end

  // Watchdog: count cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; hold it until taken. Valid is lowered only during a gap.
  task automatic send(input logic [2:0] op, input int a, input int b, input int c,
                      input int d, input int e, input int f);
    if ($urandom_range(99) < in_idle) begin
      item_valid = 0;
      while ($urandom_range(99) < in_idle) @(negedge clk);
      @(negedge clk);
    end
    item_valid = 1;
    item = '{op, a, b, c, d, e, f};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic int rnd_full();
    return int'($urandom);
  endfunction

  // Signed value within +/- span units of 1.0
  function automatic int rnd_q(int span);
    return int'($urandom_range(2 * span * QONE)) - span * QONE;
  endfunction

  task automatic random_item();
    int l, r, b, t, n, f, pick;
    pick = $urandom_range(99);
    l = rnd_q(8); b = rnd_q(8);
    r = l + int'($urandom_range(8 * QONE, 1));
    t = b + int'($urandom_range(8 * QONE, 1));
    n = int'($urandom_range(4 * QONE, 1));
    f = n + int'($urandom_range(64 * QONE, 1));
    if (pick < 8)       send(OP_IDENT, rnd_full(), rnd_full(), rnd_full(), 0, 0, 0);
    else if (pick < 25) send(OP_SCALE, rnd_q(3), rnd_q(3), rnd_q(3), 0, 0, 0);
    else if (pick < 40) send(OP_TRANSLATE, rnd_q(16), rnd_q(16), rnd_q(16), 0, 0, 0);
    else if (pick < 50) send(OP_FRUSTUM, l, r, b, t, n, f);
    else if (pick < 60) send(OP_ORTHO, l, r, b, t, -n, f);
    else if (pick < 80) send(OP_READ, rnd_full(), 0, 0, 0, 0, rnd_full());
    else begin
      // noise: any opcode, any bits
      send(3'($urandom_range(7)), rnd_full(), rnd_full(), rnd_full(),
           rnd_full(), rnd_full(), rnd_full());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extremes, every opcode, each rejection case
    send(OP_READ, 0, 0, 0, 0, 0, 0);
    send(OP_SCALE, 2 * QONE, -QONE / 2, 32'h7fffffff, 0, 0, 0);
    send(OP_TRANSLATE, 32'h80000000, 3 * QONE, -5 * QONE, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 0, 0, 0);
    send(OP_IDENT, 0, 0, 0, 0, 0, 0);
    send(OP_FRUSTUM, -QONE, QONE, -QONE, QONE, QONE, 100 * QONE);
    send(OP_FRUSTUM, -QONE, QONE, -QONE, QONE, 0, 100 * QONE);       // near not positive
    send(OP_FRUSTUM, -QONE, QONE, -QONE, QONE, QONE, -QONE);         // far not positive
    send(OP_FRUSTUM, QONE, QONE, -QONE, QONE, QONE, 9 * QONE);       // zero width
    send(OP_FRUSTUM, -QONE, QONE, QONE, -QONE, QONE, 9 * QONE);      // inverted height
    send(OP_FRUSTUM, -QONE, QONE, -QONE, QONE, 9 * QONE, 2 * QONE);  // far before near
    send(OP_ORTHO, -2 * QONE, 2 * QONE, -QONE, QONE, -QONE, 10 * QONE);
    send(OP_ORTHO, 0, 0, -QONE, QONE, 0, QONE);                      // zero width
    send(OP_ORTHO, 0, QONE, 5, 5, 0, QONE);                          // zero height
    send(OP_ORTHO, 0, QONE, 0, QONE, 7, 7);                          // zero depth
    send(OP_ORTHO, 32'h7fffffff, 32'h80000000, QONE, -QONE, QONE, -QONE);
    send(OP_READ, 0, 0, 0, 0, 0, 0);
    send(3'd6, -1, -1, -1, -1, -1, -1);
    send(3'd7, 0, 0, 0, 0, 0, 0);
    send(OP_SCALE, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    send(OP_SCALE, 0, 32'h7fffffff, 1, 0, 0, 0);
    send(OP_READ, -1, -1, -1, -1, -1, -1);

    // Hold off the sender until every result is back
    drain();

    in_idle = 16; out_idle = 59;
    repeat (85) random_item();
    in_idle = 59; out_idle = 16;
    repeat (85) random_item();
    drain();
    in_idle = 0; out_idle = 0;
    repeat (80) random_item();
    send(OP_READ, 0, 0, 0, 0, 0, 0);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
